[rtl/camera_view_matrix_assert.svh]
// Assertion macros shared by the camera view matrix RTL.
// Each macro checks a property on the rising edge of the given clock and
// is disabled while the active-low reset is asserted.
`ifndef CAMERA_VIEW_MATRIX_ASSERT_SVH
`define CAMERA_VIEW_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CVM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CVM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CVM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define CVM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/cvm_pkg.sv]
package cvm_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int UP_WIDTH        = 18;
    localparam int OUT_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    // Normalization window: the largest magnitude is scaled into [2^29, 2^30).
    localparam int NORM_LO = 29;
    localparam int NORM_HI = 30;

    // Square root and divider widths.
    localparam int SQ_WIDTH    = 64;
    localparam int SQRT_STEPS  = SQ_WIDTH / 2;
    localparam int LEN_WIDTH   = 31;

    // Operation codes.
    localparam logic [1:0] OP_PLACE  = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_MATRIX = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_X  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_Y  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_Z  = 3'd5;

    // Command to the shared square root / divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } cvm_rd_cmd_t;

    // Next vector component, wrapping after z.
    function automatic logic [1:0] next_comp(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/cvm_root_div.sv]
// Iterative integer square root (two radicand bits per cycle) and
// restoring divider (one quotient bit per cycle) sharing one control.
module cvm_root_div
    import cvm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cvm_rd_cmd_t           cmd,
    input  logic [SQ_WIDTH-1:0]   radicand,
    input  logic [LEN_WIDTH-1:0]  dividend,
    input  logic [LEN_WIDTH-1:0]  divisor,
    output logic                  done,
    output logic [LEN_WIDTH-1:0]  root,
    output logic [FRAC_BITS:0]    quotient
);

    localparam int CNT_MAX = (SQRT_STEPS - 1 > FRAC_BITS) ? SQRT_STEPS - 1 : FRAC_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [1:0] {RD_IDLE, RD_SQRT, RD_DIV} rd_state_t;

    rd_state_t               state_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SQ_WIDTH-1:0]     n_reg;
    logic [SQ_WIDTH-1:0]     r_reg;
    logic [LEN_WIDTH:0]      rem_reg;
    logic [FRAC_BITS:0]      q_reg;

    logic [SQ_WIDTH-1:0]     bit_v;
    logic [SQ_WIDTH-1:0]     trial;
    logic                    sq_ge;
    logic [LEN_WIDTH:0]      rem_sh;
    logic                    div_ge;
    logic                    start_ge;

    always_comb
    begin
        bit_v    = SQ_WIDTH'(1) << {cnt_reg, 1'b0};
        trial    = r_reg + bit_v;
        sq_ge    = (n_reg >= trial);
        rem_sh   = {rem_reg[LEN_WIDTH-1:0], 1'b0};
        div_ge   = (rem_sh >= {1'b0, divisor});
        start_ge = (dividend >= divisor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                RD_IDLE:
                begin
                    if (cmd.start)
                    begin
                        if (cmd.is_div)
                        begin
                            cnt_reg   <= CNT_W'(FRAC_BITS);
                            state_reg <= RD_DIV;
                        end
                        else
                        begin
                            cnt_reg   <= CNT_W'(SQRT_STEPS - 1);
                            state_reg <= RD_SQRT;
                        end
                    end
                end
                RD_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= RD_IDLE;
                    end
                end
                RD_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= RD_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= RD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            RD_IDLE:
            begin
                if (cmd.start)
                begin
                    n_reg   <= radicand;
                    r_reg   <= '0;
                    rem_reg <= start_ge ? {1'b0, dividend - divisor} : {1'b0, dividend};
                    q_reg   <= {{FRAC_BITS{1'b0}}, start_ge};
                end
            end
            RD_SQRT:
            begin
                if (sq_ge)
                begin
                    n_reg <= n_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_v;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
            end
            RD_DIV:
            begin
                rem_reg <= div_ge ? rem_sh - {1'b0, divisor} : rem_sh;
                q_reg   <= {q_reg[FRAC_BITS-1:0], div_ge};
            end
            default:
            begin
            end
        endcase
    end

    assign done     = done_reg;
    assign root     = r_reg[LEN_WIDTH-1:0];
    assign quotient = q_reg;

endmodule

[rtl/camera_view_matrix.sv]
// Look-at camera in signed fixed point. The block holds the camera position
// and takes the view direction and up vector from six configuration
// registers. A place beat loads the position and leaves the block ready. A move
// beat steps the position forward along the normalized direction, left along
// the normalized direction x up axis and up along the up vector, saturating
// after each of the three additions. A matrix beat returns the column-major
// 4x4 view matrix as four output beats of four entries, with last set on the
// fourth. Operation code 3 is dropped. All arithmetic runs through one
// multiply-accumulate unit (a multiply state and an accumulate state per
// product) and one iterative square root / divide unit under a small
// sequencer, and the block does not accept a new beat until the current
// one is finished. Each normalization takes the magnitudes and signs,
// scales them one bit at a time into the normalization window, sums
// their squares, takes the square root and divides each magnitude by
// it; a zero vector skips all of that.
module camera_view_matrix
    import cvm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [((COORD_WIDTH > UP_WIDTH) ? COORD_WIDTH : UP_WIDTH)-1:0] cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        operation,
    input  logic signed [COORD_WIDTH-1:0]     arg_a,
    input  logic signed [COORD_WIDTH-1:0]     arg_b,
    input  logic signed [COORD_WIDTH-1:0]     arg_c,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        column_index,
    output logic signed [OUT_WIDTH-1:0]       entry_0,
    output logic signed [OUT_WIDTH-1:0]       entry_1,
    output logic signed [OUT_WIDTH-1:0]       entry_2,
    output logic signed [OUT_WIDTH-1:0]       entry_3,
    output logic                              last
);

    localparam int P   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int UW  = UP_WIDTH;
    // Unit vector components are at most 2^F in magnitude.
    localparam int VW  = F + 2;
    // Vectors to normalize: the raw direction or an exact cross product.
    localparam int NV0 = (P > F + 21) ? P : F + 21;
    localparam int NV  = (NV0 > 2 * F + 5) ? NV0 : 2 * F + 5;
    localparam int MW  = (NV > LEN_WIDTH) ? NV : LEN_WIDTH;
    // Multiplier operands and accumulator.
    localparam int MA  = (P > LEN_WIDTH) ? P : LEN_WIDTH;
    localparam int MB  = LEN_WIDTH;
    localparam int PW  = MA + MB;
    localparam int AW  = PW + 2;

    localparam logic signed [AW-1:0] SAT_HI = {{(AW - P + 1){1'b0}}, {(P - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW - P + 1){1'b1}}, {(P - 1){1'b0}}};
    localparam logic signed [OUT_WIDTH-1:0] ONE_Q = OUT_WIDTH'(1 << F);

    typedef enum logic [2:0] {
        S_IDLE, S_NABS, S_NSCALE, S_MUL, S_ACC, S_SQRT, S_DIV, S_OUT
    } state_t;

    // Which unit vector the running normalization produces.
    typedef enum logic [1:0] {T_D, T_L, T_N} tgt_t;

    // Multiply-accumulate programs.
    typedef enum logic [2:0] {P_SQ, P_XL, P_XN, P_MOVE, P_DOT} prog_t;

    function automatic logic signed [P-1:0] sat_p(input logic signed [AW-1:0] v);
        logic signed [P-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[P-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[P-1:0];
        end
        else
        begin
            r = v[P-1:0];
        end
        return r;
    endfunction

    // Control state.
    state_t                   state_reg;
    tgt_t                     tgt_reg;
    prog_t                    prog_reg;
    logic                     job_mat_reg;
    logic [1:0]               grp_reg;
    logic [1:0]               cmp_reg;
    logic [1:0]               dcomp_reg;
    logic [1:0]               beat_reg;
    cvm_rd_cmd_t              rd_cmd_reg;
    logic signed [P-1:0]      dir_reg [3];
    logic signed [UW-1:0]     up_reg  [3];
    logic signed [P-1:0]      pos_reg [3];

    // Datapath registers.
    logic signed [P-1:0]      arg_reg [3];
    logic signed [NV-1:0]     vec_reg [3];
    logic [MW-1:0]            mag_reg [3];
    logic                     sgn_reg [3];
    logic signed [VW-1:0]     dn_reg  [3];
    logic signed [VW-1:0]     ln_reg  [3];
    logic signed [VW-1:0]     nn_reg  [3];
    logic signed [PW-1:0]     prod_reg;
    logic signed [AW-1:0]     acc_reg;
    logic [SQ_WIDTH-1:0]      sq_reg;
    logic [LEN_WIDTH-1:0]     len_reg;
    logic signed [P-1:0]      tr_reg  [3];

    // Combinational signals.
    logic [NV-1:0]            abs_v   [3];
    logic                     vec_zero;
    logic [MW-1:0]            mag_or;
    logic                     hi_hit;
    logic                     lo_miss;
    logic [1:0]               n1;
    logic [1:0]               n2;
    logic signed [MA-1:0]     opa;
    logic signed [MB-1:0]     opb;
    logic                     shift_en;
    logic                     sub_en;
    logic signed [AW-1:0]     base;
    logic signed [AW-1:0]     term;
    logic signed [AW-1:0]     acc_next;
    logic signed [VW-1:0]     q_signed;
    logic signed [VW-1:0]     unit_comp;
    logic                     norm_fin;
    logic                     rd_done;
    logic [LEN_WIDTH-1:0]     rd_root;
    logic [F:0]               rd_quot;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_v[i] = vec_reg[i][NV-1] ? (~vec_reg[i] + 1'b1) : vec_reg[i];
        end
        vec_zero = (vec_reg[0] == '0) && (vec_reg[1] == '0) && (vec_reg[2] == '0);
        mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
        hi_hit   = |mag_or[MW-1:NORM_HI];
        lo_miss  = ~|mag_or[MW-1:NORM_LO];
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        n1       = next_comp(grp_reg);
        n2       = next_comp(n1);
        opa      = '0;
        opb      = '0;
        shift_en = 1'b0;
        sub_en   = 1'b0;
        base     = (cmp_reg == 2'd0) ? '0 : acc_reg;
        case (prog_reg)
            P_SQ:
            begin
                opa = MA'($signed({1'b0, mag_reg[cmp_reg][LEN_WIDTH-2:0]}));
                opb = $signed({1'b0, mag_reg[cmp_reg][LEN_WIDTH-2:0]});
            end
            P_XL:
            begin
                // Component grp of dir x up: a[n1]*b[n2] - a[n2]*b[n1].
                sub_en = cmp_reg[0];
                opa    = MA'(cmp_reg[0] ? dn_reg[n2] : dn_reg[n1]);
                opb    = MB'(cmp_reg[0] ? up_reg[n1] : up_reg[n2]);
            end
            P_XN:
            begin
                sub_en = cmp_reg[0];
                opa    = MA'(cmp_reg[0] ? ln_reg[n2] : ln_reg[n1]);
                opb    = MB'(cmp_reg[0] ? dn_reg[n1] : dn_reg[n2]);
            end
            P_MOVE:
            begin
                shift_en = 1'b1;
                base     = AW'(pos_reg[cmp_reg]);
                case (grp_reg)
                    2'd0:
                    begin
                        opa = MA'(arg_reg[0]);
                        opb = MB'(dn_reg[cmp_reg]);
                    end
                    2'd1:
                    begin
                        opa = MA'(arg_reg[2]);
                        opb = MB'(ln_reg[cmp_reg]);
                    end
                    default:
                    begin
                        opa = MA'(arg_reg[1]);
                        opb = MB'(up_reg[cmp_reg]);
                    end
                endcase
            end
            P_DOT:
            begin
                shift_en = 1'b1;
                opa      = MA'(pos_reg[cmp_reg]);
                case (grp_reg)
                    2'd0:    opb = MB'(ln_reg[cmp_reg]);
                    2'd1:    opb = MB'(nn_reg[cmp_reg]);
                    default: opb = MB'(dn_reg[cmp_reg]);
                endcase
            end
            default:
            begin
            end
        endcase
        // Scaled products are floored, which is an arithmetic right shift.
        term     = shift_en ? (AW'(prod_reg) >>> F) : AW'(prod_reg);
        acc_next = sub_en ? (base - term) : (base + term);
    end

    always_comb
    begin
        q_signed  = $signed({1'b0, rd_quot});
        unit_comp = sgn_reg[dcomp_reg] ? -q_signed : q_signed;
        norm_fin  = ((state_reg == S_NABS) && vec_zero) ||
                    ((state_reg == S_DIV) && rd_done && (dcomp_reg == 2'd2));
    end

    // Sequencer, configuration registers and camera position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tgt_reg     <= T_D;
            prog_reg    <= P_SQ;
            job_mat_reg <= 1'b0;
            grp_reg     <= '0;
            cmp_reg     <= '0;
            dcomp_reg   <= '0;
            beat_reg    <= '0;
            rd_cmd_reg  <= '0;
            dir_reg[0]  <= P'(1 << F);
            dir_reg[1]  <= '0;
            dir_reg[2]  <= '0;
            up_reg[0]   <= '0;
            up_reg[1]   <= UW'(1 << F);
            up_reg[2]   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            rd_cmd_reg <= '0;

            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_DIR_X: dir_reg[0] <= cfg_data[P-1:0];
                    REG_DIR_Y: dir_reg[1] <= cfg_data[P-1:0];
                    REG_DIR_Z: dir_reg[2] <= cfg_data[P-1:0];
                    REG_UP_X:  up_reg[0]  <= cfg_data[UW-1:0];
                    REG_UP_Y:  up_reg[1]  <= cfg_data[UW-1:0];
                    REG_UP_Z:  up_reg[2]  <= cfg_data[UW-1:0];
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (operation)
                            OP_PLACE:
                            begin
                                pos_reg[0] <= arg_a;
                                pos_reg[1] <= arg_b;
                                pos_reg[2] <= arg_c;
                            end
                            OP_MOVE, OP_MATRIX:
                            begin
                                job_mat_reg <= (operation == OP_MATRIX);
                                tgt_reg     <= T_D;
                                state_reg   <= S_NABS;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_NABS:
                begin
                    if (!vec_zero)
                    begin
                        state_reg <= S_NSCALE;
                    end
                end
                S_NSCALE:
                begin
                    if (!hi_hit && !lo_miss)
                    begin
                        prog_reg  <= P_SQ;
                        grp_reg   <= '0;
                        cmp_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= S_MUL;
                    case (prog_reg)
                        P_SQ:
                        begin
                            if (cmp_reg == 2'd2)
                            begin
                                rd_cmd_reg <= '{start: 1'b1, is_div: 1'b0};
                                state_reg  <= S_SQRT;
                            end
                            else
                            begin
                                cmp_reg <= cmp_reg + 1'b1;
                            end
                        end
                        P_XL, P_XN:
                        begin
                            if (cmp_reg == 2'd1)
                            begin
                                cmp_reg <= '0;
                                if (grp_reg == 2'd2)
                                begin
                                    grp_reg   <= '0;
                                    tgt_reg   <= (prog_reg == P_XL) ? T_L : T_N;
                                    state_reg <= S_NABS;
                                end
                                else
                                begin
                                    grp_reg <= grp_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cmp_reg <= 2'd1;
                            end
                        end
                        P_MOVE, P_DOT:
                        begin
                            if (prog_reg == P_MOVE)
                            begin
                                pos_reg[cmp_reg] <= sat_p(acc_next);
                            end
                            if (cmp_reg == 2'd2)
                            begin
                                cmp_reg <= '0;
                                if (grp_reg == 2'd2)
                                begin
                                    grp_reg   <= '0;
                                    beat_reg  <= '0;
                                    state_reg <= (prog_reg == P_MOVE) ? S_IDLE : S_OUT;
                                end
                                else
                                begin
                                    grp_reg <= grp_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cmp_reg <= cmp_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SQRT:
                begin
                    if (rd_done)
                    begin
                        dcomp_reg  <= '0;
                        rd_cmd_reg <= '{start: 1'b1, is_div: 1'b1};
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rd_done && (dcomp_reg != 2'd2))
                    begin
                        dcomp_reg  <= dcomp_reg + 1'b1;
                        rd_cmd_reg <= '{start: 1'b1, is_div: 1'b1};
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        beat_reg <= beat_reg + 1'b1;
                        if (beat_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // A finished normalization hands over to the next program.
            if (norm_fin)
            begin
                grp_reg   <= '0;
                cmp_reg   <= '0;
                state_reg <= S_MUL;
                case (tgt_reg)
                    T_D:     prog_reg <= P_XL;
                    T_L:     prog_reg <= job_mat_reg ? P_XN : P_MOVE;
                    default: prog_reg <= P_DOT;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                arg_reg[0] <= arg_a;
                arg_reg[1] <= arg_b;
                arg_reg[2] <= arg_c;
                for (int i = 0; i < 3; i++)
                begin
                    vec_reg[i] <= NV'(dir_reg[i]);
                end
            end
            S_NABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= MW'(abs_v[i]);
                    sgn_reg[i] <= vec_reg[i][NV-1];
                    if (vec_zero)
                    begin
                        case (tgt_reg)
                            T_D:     dn_reg[i] <= '0;
                            T_L:     ln_reg[i] <= '0;
                            default: nn_reg[i] <= '0;
                        endcase
                    end
                end
            end
            S_NSCALE:
            begin
                // Right shifts truncate the magnitudes; left shifts are exact.
                for (int i = 0; i < 3; i++)
                begin
                    if (hi_hit)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (lo_miss)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_MUL:
            begin
                prod_reg <= opa * opb;
            end
            S_ACC:
            begin
                acc_reg <= acc_next;
                if ((prog_reg == P_SQ) && (cmp_reg == 2'd2))
                begin
                    sq_reg <= acc_next[SQ_WIDTH-1:0];
                end
                if (((prog_reg == P_XL) || (prog_reg == P_XN)) && (cmp_reg == 2'd1))
                begin
                    vec_reg[grp_reg] <= acc_next[NV-1:0];
                end
                if ((prog_reg == P_DOT) && (cmp_reg == 2'd2))
                begin
                    tr_reg[grp_reg] <= sat_p((grp_reg == 2'd2) ? acc_next : -acc_next);
                end
            end
            S_SQRT:
            begin
                if (rd_done)
                begin
                    len_reg <= rd_root;
                end
            end
            S_DIV:
            begin
                if (rd_done)
                begin
                    case (tgt_reg)
                        T_D:     dn_reg[dcomp_reg] <= unit_comp;
                        T_L:     ln_reg[dcomp_reg] <= unit_comp;
                        default: nn_reg[dcomp_reg] <= unit_comp;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    cvm_root_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_root_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rd_cmd_reg),
        .radicand (sq_reg),
        .dividend (mag_reg[dcomp_reg][LEN_WIDTH-1:0]),
        .divisor  (len_reg),
        .done     (rd_done),
        .root     (rd_root),
        .quotient (rd_quot)
    );

    // Output beats: columns 0..2 carry left, up and negated direction,
    // column 3 carries the translation and the homogeneous one.
    always_comb
    begin
        if (beat_reg == 2'd3)
        begin
            entry_0 = OUT_WIDTH'(tr_reg[0]);
            entry_1 = OUT_WIDTH'(tr_reg[1]);
            entry_2 = OUT_WIDTH'(tr_reg[2]);
            entry_3 = ONE_Q;
        end
        else
        begin
            entry_0 = OUT_WIDTH'(ln_reg[beat_reg]);
            entry_1 = OUT_WIDTH'(nn_reg[beat_reg]);
            entry_2 = OUT_WIDTH'(-dn_reg[beat_reg]);
            entry_3 = '0;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign column_index = beat_reg;
    assign last         = (beat_reg == 2'd3);

`include "camera_view_matrix_assert.svh"

    // The shared unit only reports back while the sequencer waits for it.
    `CVM_ASSERT_IMP(a_rd_done_expected, clk, rst_n, rd_done, (state_reg == S_SQRT) || (state_reg == S_DIV), "root/div done outside of a wait state")

    // A scaled, nonzero vector always has a length in [2^29, 2^31).
    `CVM_ASSERT_IMP(a_len_window, clk, rst_n, rd_done && (state_reg == S_SQRT), rd_root[LEN_WIDTH-1:NORM_LO] != '0, "vector length outside the normalization window")

    // Scaling never runs on an all-zero vector.
    `CVM_ASSERT_IMP(a_scale_nonzero, clk, rst_n, state_reg == S_NSCALE, mag_or != '0, "scaling an all-zero vector")

    // After the last matrix beat the block is ready again.
    `CVM_ASSERT_NEXT(a_ready_after_last, clk, rst_n, out_valid && out_ready && last, in_ready, "not ready after the last matrix beat")

endmodule
